// ----- src/mme_pkg.sv -----
`default_nettype none

package mme_pkg;

  // field widths fixed by the item format
  localparam int unsigned OpW     = 2;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned ElemW   = 16;
  localparam int unsigned ProdW   = 2 * ElemW;
  localparam int unsigned AccW    = 38;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned MaxDimDefault = 64;
  localparam logic [CfgW-1:0] CfgResetVal = 7'd64;

  typedef enum logic [OpW-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_READ_C  = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_COUNT  = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COL_COUNT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [OpW-1:0]          opcode;
    logic [IdxW-1:0]         row_index;
    logic [IdxW-1:0]         col_index;
    logic signed [ElemW-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [AccW-1:0] product_value;
    logic                   status;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/mme_ram.sv -----
`default_nettype none

module mme_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/matrix_multiply_engine.sv -----
`default_nettype none

// Channel   Direction  Payload            Handshake
// in        input      mme_pkg::in_item_t  in_valid_i / in_stall_o
// out       output     mme_pkg::out_item_t out_valid_o / out_stall_i
// cfg       input      7-bit register      cfg_we_i, cfg_idx_i (no wait)
//
// Writes of A or B leave the input free. A read of C stalls the input from its
// transfer until its result enters the output register: one A/B element pair
// leaves the two RAM read ports per cycle into a single multiply-accumulate unit
// (RAM read, product register, accumulate). Out-of-range reads return status 1.
// Reset clears control and configuration only; the A and B RAMs are never cleared.
// The result sits in an output register, so new transfers are taken while it
// waits; a finished read waits in DONE only if that register is still full.

module matrix_multiply_engine #(
  parameter int unsigned MAX_DIM = mme_pkg::MaxDimDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire mme_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output mme_pkg::out_item_t                  out_item_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mme_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [mme_pkg::CfgW-1:0]       cfg_wdata_i
);

  import mme_pkg::*;

  localparam int unsigned DimW  = $clog2(MAX_DIM);
  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW = $clog2(Depth);
  // count width: holds a config value and MAX_DIM itself
  localparam int unsigned CntW  = ($clog2(MAX_DIM + 1) > CfgW) ? $clog2(MAX_DIM + 1) : CfgW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  function automatic logic [AddrW-1:0] elem_addr(input logic [DimW-1:0] row,
                                                 input logic [DimW-1:0] col);
    return AddrW'(row) * AddrW'(MAX_DIM) + AddrW'(col);
  endfunction

  function automatic logic [CntW-1:0] eff_dim(input logic [CfgW-1:0] val);
    logic [CntW-1:0] ext;
    ext = CntW'(val);
    return (ext > CntW'(MAX_DIM)) ? CntW'(MAX_DIM) : ext;
  endfunction

  // configuration
  logic [CfgW-1:0] row_count_q, inner_size_q, col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q  <= CfgResetVal;
      inner_size_q <= CfgResetVal;
      col_count_q  <= CfgResetVal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_COUNT:  row_count_q  <= cfg_wdata_i;
        CFG_INNER_SIZE: inner_size_q <= cfg_wdata_i;
        CFG_COL_COUNT:  col_count_q  <= cfg_wdata_i;
        default: ;  // unused index, dropped
      endcase
    end
  end

  logic [CntW-1:0] nr, nk, nc;
  assign nr = eff_dim(row_count_q);
  assign nk = eff_dim(inner_size_q);
  assign nc = eff_dim(col_count_q);

  // input decode
  logic            in_xfer;
  logic [CntW-1:0] in_row, in_col;
  logic            a_wr_ok, b_wr_ok, rd_err;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign in_row  = CntW'(in_item_i.row_index);
  assign in_col  = CntW'(in_item_i.col_index);
  assign a_wr_ok = (in_row < nr) && (in_col < nk);
  assign b_wr_ok = (in_row < nk) && (in_col < nc);
  assign rd_err  = (in_row >= nr) || (in_col >= nc) || (nk == '0);

  // control state
  state_e              state_q, state_d;
  logic [CntW-1:0]     k_q, k_d;
  logic [DimW-1:0]     r_q, c_q;
  logic                err_q, err_d;
  logic                rd_v_q, prod_v_q;
  logic                issue;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q;
  logic                out_load;

  // RAM ports
  logic             a_we, b_we;
  logic [AddrW-1:0] waddr, a_raddr, b_raddr;
  logic [ElemW-1:0] a_rdata, b_rdata;

  assign waddr   = elem_addr(DimW'(in_item_i.row_index), DimW'(in_item_i.col_index));
  assign a_we    = in_xfer && (in_item_i.opcode == OP_WRITE_A) && a_wr_ok;
  assign b_we    = in_xfer && (in_item_i.opcode == OP_WRITE_B) && b_wr_ok;
  assign a_raddr = elem_addr(r_q, k_q[DimW-1:0]);
  assign b_raddr = elem_addr(k_q[DimW-1:0], c_q);

  mme_ram #(.Width(ElemW), .Depth(Depth)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.element_value),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mme_ram #(.Width(ElemW), .Depth(Depth)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.element_value),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // writes never overlap a read walk: input is stalled outside IDLE
  assign in_stall_o = (state_q != ST_IDLE);
  assign issue      = (state_q == ST_RUN) && (k_q < nk);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    err_d   = err_q;
    acc_d   = acc_q;
    if (prod_v_q) begin
      acc_d = acc_q + AccW'(prod_q);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_item_i.opcode == OP_READ_C)) begin
          k_d   = '0;
          acc_d = '0;
          err_d = rd_err;
          state_d = rd_err ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          k_d = k_q + CntW'(1);
        end else if (!rd_v_q && !prod_v_q) begin
          state_d = ST_DONE;  // pipeline drained, acc final
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_v_q      <= issue;
      prod_v_q    <= rd_v_q;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    err_q <= err_d;
    acc_q <= acc_d;
    if (in_xfer) begin
      r_q <= DimW'(in_item_i.row_index);
      c_q <= DimW'(in_item_i.col_index);
    end
    if (rd_v_q) begin
      prod_q <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (out_load) begin
      out_q.product_value <= err_q ? '0 : acc_q;
      out_q.status        <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- src/mme_checker.sv -----
`default_nettype none

module mme_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire mme_pkg::in_item_t           in_item_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire mme_pkg::out_item_t          out_item_o,
  input wire logic                        cfg_we_i,
  input wire logic [mme_pkg::CfgIdxW-1:0] cfg_idx_i,
  input wire logic [mme_pkg::CfgW-1:0]    cfg_wdata_i
);

  import mme_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status |-> out_item_o.product_value == '0)
    else $error("error result with nonzero value");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_item_i.opcode == OP_READ_C |=> in_stall_o)
    else $error("read transfer did not occupy the engine");

  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_item_i.opcode != OP_READ_C |=> !in_stall_o)
    else $error("write transfer took more than one cycle");

  logic unused_cfg;
  assign unused_cfg = cfg_we_i ^ (^cfg_idx_i) ^ (^cfg_wdata_i);

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

`default_nettype wire

// ----- bench/mme_tb_pkg.sv -----
package mme_tb_pkg;
  import mme_pkg::*;

  localparam int unsigned Dim       = MaxDimDefault;
  localparam int unsigned ReportCap = 40;

  // Mirror of the engine: element stores, live sizes, reads still owed.
  class mme_product_model;
    logic signed [ElemW-1:0] a_elem [Dim*Dim];
    logic signed [ElemW-1:0] b_elem [Dim*Dim];
    bit                      a_set  [Dim*Dim];
    bit                      b_set  [Dim*Dim];
    int unsigned             rows;
    int unsigned             inner;
    int unsigned             cols;
    out_item_t               products_due [$];
    int unsigned             mismatch_count;
    int unsigned             reads_checked;
    int unsigned             range_errors;

    function new();
      set_dims(32'(CfgResetVal), 32'(CfgResetVal), 32'(CfgResetVal));
    endfunction

    // register values above Dim act as Dim
    function void set_dims(int unsigned r, int unsigned k, int unsigned c);
      rows  = (r > Dim) ? Dim : r;
      inner = (k > Dim) ? Dim : k;
      cols  = (c > Dim) ? Dim : c;
    endfunction

    function bit read_in_range(int unsigned r, int unsigned c);
      return (r < rows) && (c < cols) && (inner != 0);
    endfunction

    function bit takes_effect(in_item_t item);
      case (item.opcode)
        OP_WRITE_A: return (item.row_index < rows) && (item.col_index < inner);
        OP_WRITE_B: return (item.row_index < inner) && (item.col_index < cols);
        OP_READ_C:  return 1'b1;
        default:    return 1'b0;
      endcase
    endfunction

    function int unsigned pending();
      return products_due.size();
    endfunction

    function void note_item(in_item_t item);
      int unsigned r;
      int unsigned c;
      int unsigned k;
      longint      acc;
      out_item_t   res;
      r   = 32'(item.row_index);
      c   = 32'(item.col_index);
      acc = 0;
      res = '0;
      case (item.opcode)
        OP_WRITE_A: begin
          if (r < rows && c < inner) begin
            a_elem[r*Dim+c] = item.element_value;
            a_set[r*Dim+c]  = 1'b1;
          end
        end
        OP_WRITE_B: begin
          if (r < inner && c < cols) begin
            b_elem[r*Dim+c] = item.element_value;
            b_set[r*Dim+c]  = 1'b1;
          end
        end
        OP_READ_C: begin
          if (read_in_range(r, c)) begin
            for (k = 0; k < inner; k++)
              acc += longint'(a_elem[r*Dim+k]) * longint'(b_elem[k*Dim+c]);
            res.product_value = acc[AccW-1:0];
          end else begin
            res.status = 1'b1;
            range_errors++;
          end
          products_due.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= ReportCap)
        $display("mismatch on read %0d: %s", reads_checked, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (products_due.size() == 0) begin
        report_mismatch($sformatf("result with no read pending: value %0d status %0b",
                                  got.product_value, got.status));
        return;
      end
      want = products_due.pop_front();
      reads_checked++;
      if (got.product_value !== want.product_value)
        report_mismatch($sformatf("product_value got %0d want %0d",
                                  got.product_value, want.product_value));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0b want %0b", got.status, want.status));
    endtask
  endclass

endpackage

// ----- bench/tb_matrix_multiply_engine.sv -----
module tb_matrix_multiply_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import mme_pkg::*;
  import mme_tb_pkg::*;

  localparam int unsigned ResetCycles  = 12;
  // wait that covers the longest read with margin
  localparam int unsigned SettleCycles = 80;
  // cycles without any transfer before the run is declared hung
  localparam int unsigned StuckLimit   = 4000;
  localparam int unsigned RandomQuota  = 480;

  localparam logic [OpW-1:0]   OpUnused = 2'd3;   // no operation behind it
  localparam logic [ElemW-1:0] ElemMin  = 16'h8000;
  localparam logic [ElemW-1:0] ElemMax  = 16'h7fff;
  localparam logic [ElemW-1:0] ElemOne  = 16'h0100;  // 1.0 in Q8.8
  localparam logic [ElemW-1:0] ElemNeg  = 16'hffff;  // smallest negative step

  // size settings for the random part: rows, inner, cols and effective-transfer quota
  localparam int PhaseCount = 10;
  int unsigned phase_rows  [PhaseCount] = '{4, 1, 6, 3,  0, 7, 64, 2,  127, 5};
  int unsigned phase_inner [PhaseCount] = '{4, 1, 3, 12, 5, 0, 2,  64, 127, 6};
  int unsigned phase_cols  [PhaseCount] = '{4, 1, 5, 2,  3, 7, 64, 3,  127, 7};
  int unsigned phase_quota [PhaseCount] = '{60, 30, 60, 55, 20, 20, 60, 50, 65, 60};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_item;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = CFG_ROW_COUNT;
  logic [CfgW-1:0]    cfg_wdata = '0;

  mme_product_model model;
  int unsigned      idle_pct     = 34;   // sender gap odds, percent per cycle
  int unsigned      stall_pct    = 62;   // receiver stall odds, percent per cycle
  int unsigned      items_taken  = 0;    // transfers that write or read something
  int unsigned      dims_written = 0;
  int unsigned      stuck_cycles = 0;

  matrix_multiply_engine dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: stalls at random, odds set by the current pacing mode.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor. Sampled on the falling edge, where everything driven at the rising
  // edge has settled; a transfer seen here completes at the next rising edge.
  // Output is checked before input is noted: a read's result can never come
  // back in the cycle it is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        model.check_result(out_item);
      if (in_valid && !in_stall)
        model.note_item(in_item);
    end
    if ((out_valid && !out_stall) || (in_valid && !in_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
  end

  // Watchdog: a lost result or a wedged handshake ends up here.
  initial begin
    while (stuck_cycles < StuckLimit)
      @(posedge clk);
    $display("tb_matrix_multiply_engine: done, errors");
    $finish;
  end

  // One input transfer. Called right after a rising edge, returns right after
  // the edge that took the item; valid stays high for back-to-back transfers.
  task automatic send_item(input in_item_t item);
    if (model.takes_effect(item))
      items_taken++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
  endtask

  task automatic put(input logic [OpW-1:0] op, input int unsigned row,
                     input int unsigned col, input logic [ElemW-1:0] value);
    in_item_t item;
    item.opcode        = op;
    item.row_index     = row[IdxW-1:0];
    item.col_index     = col[IdxW-1:0];
    item.element_value = value;
    send_item(item);
  endtask

  // Read of one product element. Every A and B element the dot product will
  // touch is written first if it never was, so no stale RAM word is read.
  task automatic read_product(input int unsigned row, input int unsigned col);
    int unsigned k;
    if (model.read_in_range(row, col)) begin
      for (k = 0; k < model.inner; k++) begin
        if (!model.a_set[row*Dim+k])
          put(OP_WRITE_A, row, k, ElemW'($urandom_range(16'hffff)));
        if (!model.b_set[k*Dim+col])
          put(OP_WRITE_B, k, col, ElemW'($urandom_range(16'hffff)));
      end
    end
    put(OP_READ_C, row, col, ElemW'($urandom_range(16'hffff)));
  endtask

  // Sender holds off until every owed result is back. Always spends at least
  // one edge so valid is never lowered and raised in the same step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
  endtask

  // Size registers change only with the engine empty: results drained, then
  // enough cycles for a trailing write to retire.
  task automatic set_dims(input int unsigned rows, input int unsigned inner,
                          input int unsigned cols);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ROW_COUNT;
    cfg_wdata <= rows[CfgW-1:0];
    @(posedge clk);
    cfg_idx   <= CFG_INNER_SIZE;
    cfg_wdata <= inner[CfgW-1:0];
    @(posedge clk);
    cfg_idx   <= CFG_COL_COUNT;
    cfg_wdata <= cols[CfgW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    model.set_dims(rows, inner, cols);
    dims_written++;
  endtask

  // Mostly in range, biased to low indices on large sizes to keep read setup
  // short; a slice of picks spans the whole index field.
  function automatic int unsigned pick_index(input int unsigned dim);
    int unsigned lim;
    lim = dim;
    if (lim > 8 && $urandom_range(3) != 0)
      lim = 8;
    if (lim == 0 || $urandom_range(99) < 12)
      return $urandom_range(Dim - 1);
    return $urandom_range(lim - 1);
  endfunction

  task automatic random_action();
    int unsigned roll;
    in_item_t    item;
    if ($urandom_range(99) < 2)
      drain_results();
    roll = $urandom_range(99);
    if (roll < 30) begin
      put(OP_WRITE_A, pick_index(model.rows), pick_index(model.inner),
          ElemW'($urandom_range(16'hffff)));
    end else if (roll < 58) begin
      put(OP_WRITE_B, pick_index(model.inner), pick_index(model.cols),
          ElemW'($urandom_range(16'hffff)));
    end else if (roll < 92) begin
      read_product(pick_index(model.rows), pick_index(model.cols));
    end else begin
      // raw noise over every field, unused opcode included
      item = in_item_t'($urandom);
      if (item.opcode == OP_READ_C)
        read_product(32'(item.row_index), 32'(item.col_index));
      else
        send_item(item);
    end
  endtask

  initial begin
    int unsigned k;
    int unsigned p;
    int unsigned random_start;
    int unsigned phase_end;
    int unsigned done;

    model = new();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 2x2 operands at the Q8.8 extremes, out-of-range reads and
    // writes, the unused opcode, then zero inner size.
    set_dims(2, 2, 2);
    put(OP_WRITE_A, 0, 0, ElemMin);
    put(OP_WRITE_A, 0, 1, ElemMax);
    put(OP_WRITE_A, 1, 0, ElemOne);
    put(OP_WRITE_A, 1, 1, ElemNeg);
    put(OP_WRITE_B, 0, 0, ElemMin);
    put(OP_WRITE_B, 1, 0, ElemMax);
    put(OP_WRITE_B, 0, 1, ElemMin);
    put(OP_WRITE_B, 1, 1, ElemMin);
    put(OP_READ_C, 0, 0, '0);
    put(OP_READ_C, 0, 1, '0);
    put(OP_READ_C, 1, 0, '0);
    put(OP_READ_C, 1, 1, '0);
    put(OP_READ_C, 2, 0, '0);
    put(OP_READ_C, 0, 2, '0);
    put(OP_READ_C, Dim - 1, Dim - 1, '0);
    // ignored writes must leave the stores alone
    put(OP_WRITE_A, 2, 0, ElemMax);
    put(OP_WRITE_A, 0, 2, ElemMax);
    put(OP_WRITE_B, 2, 0, ElemMax);
    put(OP_WRITE_B, 0, Dim - 1, ElemMax);
    put(OpUnused, 1, 1, ElemMax);
    put(OP_READ_C, 0, 0, '0);

    set_dims(2, 0, 2);
    put(OP_READ_C, 0, 0, '0);
    put(OP_READ_C, 1, 1, '0);

    // Register values past the array size; largest magnitudes of both signs
    // summed over the full inner length.
    set_dims(127, 127, 127);
    for (k = 0; k < Dim; k++) begin
      put(OP_WRITE_A, Dim - 1, k, ElemMin);
      put(OP_WRITE_A, Dim - 2, k, ElemMax);
      put(OP_WRITE_B, k, Dim - 1, ElemMin);
    end
    put(OP_READ_C, Dim - 1, Dim - 1, '0);
    put(OP_READ_C, Dim - 2, Dim - 1, '0);
    read_product(0, 0);

    // Random part. Pacing: sender gaps with heavy receiver stalls, then the
    // reverse, then full speed on both sides.
    random_start = items_taken;
    for (p = 0; p < PhaseCount; p++) begin
      set_dims(phase_rows[p], phase_inner[p], phase_cols[p]);
      phase_end = items_taken + phase_quota[p];
      while (items_taken < phase_end) begin
        done = items_taken - random_start;
        if (done < RandomQuota / 3) begin
          idle_pct  = 34;
          stall_pct = 62;
        end else if (done < 2 * RandomQuota / 3) begin
          idle_pct  = 62;
          stall_pct = 34;
        end else begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        random_action();
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    $display("summary: %0d effective input transfers, %0d products checked (%0d out of range)",
             items_taken, model.reads_checked, model.range_errors);
    $display("summary: %0d size settings from 0 to 127, three pacing modes",
             dims_written);
    if (model.mismatch_count == 0)
      $display("tb_matrix_multiply_engine: done, clean");
    else
      $display("tb_matrix_multiply_engine: done, errors");
    $finish;
  end

endmodule

// ----- matrix_multiply_engine.f -----
src/mme_pkg.sv
src/mme_ram.sv
src/matrix_multiply_engine.sv
src/mme_checker.sv
bench/mme_tb_pkg.sv
bench/tb_matrix_multiply_engine.sv
